FILE: design/rdpd_pkg.sv
// ----------------------------------------------------------------------------
// rdpd_pkg
// Shared types, framing characters and the hex digit decoder for the
// remote debug packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rdpd_pkg;

  // framing characters
  localparam logic [7:0] CH_ACK   = 8'h2B;
  localparam logic [7:0] CH_NAK   = 8'h2D;
  localparam logic [7:0] CH_BREAK = 8'h03;
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_CONTROL = 2'd2;

  // framing phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_LOW  = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // one ascii hex digit, either case; value 0 when not hex
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] t;
    h = '0;
    t = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      h.ok = 1'b1;
      h.val = t[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      h.ok = 1'b1;
      h.val = t[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      h.ok = 1'b1;
      h.val = t[3:0];
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: design/remote_debug_packet_deframer.sv
// ----------------------------------------------------------------------------
// remote_debug_packet_deframer
// Recovers packet framing from a serial byte stream: control bytes,
// payload bytes with a running sum, and a checked end of packet.
// ----------------------------------------------------------------------------
//
//   channel  direction  ports                                          flow
//   in       input      in_valid, in_stall, in_rx_byte                 1 word
//   out      output     out_valid, out_stall, out_kind, out_value,     0 or 1
//                       out_checksum_ok, out_received_sum,             word
//                       out_computed_sum
//
// one word per cycle sustained while no result waits under out_stall; a word
// passes through the input register, then through the phase step into the
// result register.
// synchronous active-low reset empties both registers and returns to idle.
// the input register holds while a result waits under out_stall; a word that
// yields no result still passes only when the result register is free.
//
`default_nettype none

module remote_debug_packet_deframer
  import rdpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_value,
  output logic            out_checksum_ok,
  output logic [7:0]      out_received_sum,
  output logic [7:0]      out_computed_sum
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;

  logic [1:0] phase_r,  phase_nxt;
  logic [7:0] sum_r,    sum_nxt;
  logic [3:0] nib_r,    nib_nxt;
  logic       nib_bad_r, nib_bad_nxt;

  logic       res_valid_nxt;
  logic [1:0] res_kind_nxt;
  logic [7:0] res_value_nxt;
  logic       res_ok_nxt;
  logic [7:0] res_rsum_nxt;
  logic [7:0] res_csum_nxt;

  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_value_r;
  logic       out_ok_r;
  logic [7:0] out_rsum_r;
  logic [7:0] out_csum_r;

  logic       out_free;
  logic       step;
  hex_t       hex;
  logic [7:0] rsum;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  assign hex  = hex_decode(in_byte_r);
  assign rsum = {nib_r, hex.val};

  always_comb begin
    phase_nxt     = phase_r;
    sum_nxt       = sum_r;
    nib_nxt       = nib_r;
    nib_bad_nxt   = nib_bad_r;
    res_valid_nxt = 1'b0;
    res_kind_nxt  = KIND_PAYLOAD;
    res_value_nxt = 8'd0;
    res_ok_nxt    = 1'b0;
    res_rsum_nxt  = 8'd0;
    res_csum_nxt  = 8'd0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_byte_r == CH_ACK || in_byte_r == CH_NAK || in_byte_r == CH_BREAK) begin
          res_valid_nxt = 1'b1;
          res_kind_nxt  = KIND_CONTROL;
          res_value_nxt = in_byte_r;
          res_ok_nxt    = 1'b1;
        end else if (in_byte_r == CH_START) begin
          sum_nxt   = 8'd0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (in_byte_r == CH_HASH) begin
          phase_nxt = PH_HIGH;
        end else begin
          sum_nxt       = sum_r + in_byte_r;
          res_valid_nxt = 1'b1;
          res_kind_nxt  = KIND_PAYLOAD;
          res_value_nxt = in_byte_r;
        end
      end
      PH_HIGH: begin
        nib_nxt     = hex.val;
        nib_bad_nxt = !hex.ok;
        phase_nxt   = PH_LOW;
      end
      PH_LOW: begin
        res_valid_nxt = 1'b1;
        res_kind_nxt  = KIND_END;
        res_ok_nxt    = hex.ok && !nib_bad_r && (rsum == sum_r);
        res_rsum_nxt  = rsum;
        res_csum_nxt  = sum_r;
        phase_nxt     = PH_IDLE;
        sum_nxt       = 8'd0;
        nib_nxt       = 4'd0;
        nib_bad_nxt   = 1'b0;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      sum_r     <= 8'd0;
      nib_r     <= 4'd0;
      nib_bad_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      sum_r     <= sum_nxt;
      nib_r     <= nib_nxt;
      nib_bad_r <= nib_bad_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_valid_nxt) begin
      out_kind_r  <= res_kind_nxt;
      out_value_r <= res_value_nxt;
      out_ok_r    <= res_ok_nxt;
      out_rsum_r  <= res_rsum_nxt;
      out_csum_r  <= res_csum_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_checksum_ok  = out_ok_r;
  assign out_received_sum = out_rsum_r;
  assign out_computed_sum = out_csum_r;

endmodule

`default_nettype wire

FILE: verif/remote_debug_packet_deframer_test.sv
// ----------------------------------------------------------------------------
// remote_debug_packet_deframer_test
// Drives byte streams through the deframer and compares every result word
// with a model of the framing held in this testbench.
// ----------------------------------------------------------------------------
// a table of directed bytes comes first (control bytes, stray bytes, an empty
// packet, framing bytes used as payload, bad checksum digits), then random
// packets with correct, wrong and non-hex checksums mixed with control bytes
// and noise. sender gaps and receiver stalls change between phases, and one
// long receiver hold-off fills the block up so that it stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_debug_packet_deframer_test
  import rdpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 1880;
  localparam int unsigned HOLD_OFF_CYCLES = 60;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       ok;
    logic [7:0] rsum;
    logic [7:0] csum;
  } frame_res_t;

  // directed row: the expected result is typed in only where fixed is set
  typedef struct packed {
    logic [7:0] b;
    bit         fixed;
    bit         emits;
    frame_res_t res;
  } frame_row_t;

  localparam frame_res_t NO_RES = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_value;
  logic       out_checksum_ok;
  logic [7:0] out_received_sum;
  logic [7:0] out_computed_sum;

  // framing model state
  logic [1:0] frame_phase = PH_IDLE;
  logic [7:0] payload_sum = 8'd0;
  logic [3:0] ck_high = 4'd0;
  bit         ck_high_bad = 1'b0;

  frame_res_t  pending_results[$];
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  bit          squeeze_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_words = 0;
  int unsigned n_results = 0;
  int unsigned n_ends = 0;
  int unsigned n_good_ends = 0;
  int unsigned n_input_stalls = 0;

  remote_debug_packet_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_checksum_ok  (out_checksum_ok),
    .out_received_sum (out_received_sum),
    .out_computed_sum (out_computed_sum)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
      return 1'b1;
    end
    // low nibble of 'A'..'F' and 'a'..'f' is 1..6
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return (upper ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom); while (hex_val(c, v));
    return c;
  endfunction

  // one byte through the framing model; returns 1 when it yields a result
  function automatic bit frame_step(input logic [7:0] b, output frame_res_t r);
    logic [3:0] nib;
    bit         good;
    bit         got;
    logic [7:0] rsum;
    r = NO_RES;
    got = 1'b0;
    case (frame_phase)
      PH_IDLE: begin
        if (b == CH_ACK || b == CH_NAK || b == CH_BREAK) begin
          r.kind = KIND_CONTROL;
          r.value = b;
          r.ok = 1'b1;
          got = 1'b1;
        end else if (b == CH_START) begin
          payload_sum = 8'd0;
          frame_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (b == CH_HASH) begin
          frame_phase = PH_HIGH;
        end else begin
          payload_sum = payload_sum + b;
          r.kind = KIND_PAYLOAD;
          r.value = b;
          got = 1'b1;
        end
      end
      PH_HIGH: begin
        good = hex_val(b, nib);
        ck_high = nib;
        ck_high_bad = !good;
        frame_phase = PH_LOW;
      end
      default: begin
        good = hex_val(b, nib);
        rsum = {ck_high, nib};
        r.kind = KIND_END;
        r.ok = good && !ck_high_bad && (rsum == payload_sum);
        r.rsum = rsum;
        r.csum = payload_sum;
        got = 1'b1;
        frame_phase = PH_IDLE;
        payload_sum = 8'd0;
        ck_high = 4'd0;
        ck_high_bad = 1'b0;
      end
    endcase
    return got;
  endfunction

  // offer one word, wait for it to be taken, then record what it should yield
  task automatic send_byte(input logic [7:0] b, input bit fixed, input bit emits,
                           input frame_res_t fixed_res);
    frame_res_t r;
    bit         got;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_words++;
    got = frame_step(b, r);
    if (fixed) begin
      if (emits) pending_results.push_back(fixed_res);
    end else if (got) begin
      pending_results.push_back(r);
    end
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [7:0]  ck;
    logic [7:0]  hi;
    logic [7:0]  lo;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case ($urandom_range(0, 2))
        0: b = CH_ACK;
        1: b = CH_NAK;
        default: b = CH_BREAK;
      endcase
      send_byte(b, 1'b0, 1'b0, NO_RES);
    end else if (pick < 16) begin
      // noise between packets; a stray '$' simply opens a packet
      send_byte(8'($urandom), 1'b0, 1'b0, NO_RES);
    end else begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      sum = 8'd0;
      send_byte(CH_START, 1'b0, 1'b0, NO_RES);
      repeat (len) begin
        b = 8'($urandom);
        if (b == CH_HASH) b = b ^ 8'h01;
        sum = sum + b;
        send_byte(b, 1'b0, 1'b0, NO_RES);
      end
      send_byte(CH_HASH, 1'b0, 1'b0, NO_RES);
      pick = $urandom_range(0, 99);
      ck = (pick < 12) ? sum + 8'($urandom_range(1, 255)) : sum;
      hi = hex_char(ck[7:4], $urandom_range(0, 1) == 1);
      lo = hex_char(ck[3:0], $urandom_range(0, 1) == 1);
      if (pick >= 88 && pick < 94) hi = non_hex_char();
      if (pick >= 94) lo = non_hex_char();
      if (pick >= 98) hi = non_hex_char();
      send_byte(hi, 1'b0, 1'b0, NO_RES);
      send_byte(lo, 1'b0, 1'b0, NO_RES);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (squeeze_req) begin
      squeeze_req <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("** remote_debug_packet_deframer: FAILED **");
      $finish;
    end
    if (rst_n && in_valid && in_stall) n_input_stalls++;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d value 0x%0h",
               out_kind, out_value);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        check_field("kind", e.kind, out_kind);
        check_field("value", e.value, out_value);
        check_field("checksum_ok", e.ok, out_checksum_ok);
        check_field("received_sum", e.rsum, out_received_sum);
        check_field("computed_sum", e.csum, out_computed_sum);
        if (e.kind == KIND_END) begin
          n_ends++;
          if (e.ok) n_good_ends++;
        end
      end
    end
  end

  initial begin
    frame_row_t dir_rows[24];
    int unsigned start_words;
    dir_rows = '{
      '{CH_ACK,   1'b1, 1'b1, '{KIND_CONTROL, CH_ACK,   1'b1, 8'h00, 8'h00}},
      '{CH_NAK,   1'b1, 1'b1, '{KIND_CONTROL, CH_NAK,   1'b1, 8'h00, 8'h00}},
      '{CH_BREAK, 1'b1, 1'b1, '{KIND_CONTROL, CH_BREAK, 1'b1, 8'h00, 8'h00}},
      '{8'h00,    1'b1, 1'b0, NO_RES},
      '{8'hFF,    1'b1, 1'b0, NO_RES},
      // empty packet "$#00"
      '{CH_START, 1'b1, 1'b0, NO_RES},
      '{CH_HASH,  1'b1, 1'b0, NO_RES},
      '{8'h30,    1'b1, 1'b0, NO_RES},
      '{8'h30,    1'b1, 1'b1, '{KIND_END, 8'h00, 1'b1, 8'h00, 8'h00}},
      // framing bytes inside a packet are payload; checksum 0x7e in lower case
      '{CH_START, 1'b1, 1'b0, NO_RES},
      '{8'hFF,    1'b0, 1'b0, NO_RES},
      '{CH_START, 1'b0, 1'b0, NO_RES},
      '{CH_ACK,   1'b0, 1'b0, NO_RES},
      '{CH_NAK,   1'b0, 1'b0, NO_RES},
      '{CH_BREAK, 1'b0, 1'b0, NO_RES},
      '{8'h00,    1'b0, 1'b0, NO_RES},
      '{CH_HASH,  1'b1, 1'b0, NO_RES},
      '{8'h37,    1'b1, 1'b0, NO_RES},
      '{8'h65,    1'b0, 1'b0, NO_RES},
      // non-hex first digit "$A#G1"
      '{CH_START, 1'b1, 1'b0, NO_RES},
      '{8'h41,    1'b0, 1'b0, NO_RES},
      '{CH_HASH,  1'b1, 1'b0, NO_RES},
      '{8'h47,    1'b1, 1'b0, NO_RES},
      '{8'h31,    1'b1, 1'b1, '{KIND_END, 8'h00, 1'b0, 8'h01, 8'h41}}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].emits, dir_rows[i].res);

    // random packets: no idling (with the long hold-off), sender gaps,
    // receiver stalls, then both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct <= 0;  squeeze_req <= 1'b1; end
        1: begin snd_idle_pct = 65; rcv_stall_pct <= 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct <= 65; end
        default: begin snd_idle_pct = 13; rcv_stall_pct <= 13; end
      endcase
      start_words = n_words;
      while (n_words - start_words < RANDOM_WORDS / 4) send_random_frame();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d words in, %0d results out, %0d packets closed (%0d with good checksum)",
             n_words, n_results, n_ends, n_good_ends);
    $display("input held back by a full block on %0d cycles", n_input_stalls);
    if (mismatches == 0) begin
      $display("** remote_debug_packet_deframer: PASSED **");
    end else begin
      $display("** remote_debug_packet_deframer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: remote_debug_packet_deframer.f
design/rdpd_pkg.sv
design/remote_debug_packet_deframer.sv
verif/remote_debug_packet_deframer_test.sv
